@@ rtl/dsdcic_pkg.sv @@
// Shared types, widths and helper functions for the stereo DSD CIC decimator.
// Depends on nothing; every other file of the block imports it.
package dsdcic_pkg;

	localparam int ACC_WIDTH_DEF = 32;

	localparam int BITS_PER_BYTE = 8;
	localparam int BYTES         = 8;
	localparam int DSD_W         = BYTES * BITS_PER_BYTE;
	localparam int ITEM_LEN      = DSD_W;
	// Weight of the oldest sample on the third integrator over one item.
	localparam int ITEM_TRI      = ITEM_LEN * (ITEM_LEN + 1) / 2;

	// Moments of one byte: |m0| <= 8, |m1| <= 36, |m2| <= 120.
	localparam int BM0_W = 5;
	localparam int BM1_W = 7;
	localparam int BM2_W = 8;
	// Moments of one item: |m0| <= 64, |m1| <= 2080, |m2| <= 45760.
	localparam int IM0_W = 8;
	localparam int IM1_W = 13;
	localparam int IM2_W = 17;

	localparam int PCM_W       = 30;
	localparam int PCM_SHIFT   = 10;
	localparam int TDATA_IN_W  = 2 * DSD_W;
	localparam int TDATA_OUT_W = 64;

	typedef struct packed {
		logic signed [BM0_W-1:0] m0;
		logic signed [BM1_W-1:0] m1;
		logic signed [BM2_W-1:0] m2;
	} byte_mom_t;

	typedef struct packed {
		logic signed [IM0_W-1:0] m0;
		logic signed [IM1_W-1:0] m1;
		logic signed [IM2_W-1:0] m2;
	} item_mom_t;

	// Per-stage control handed to a channel: update the stage, and clear its state first.
	typedef struct packed {
		logic load;
		logic restart;
	} stage_ctl_t;

	// Sum, first and second moment of the eight +1/-1 samples in one byte.
	function automatic byte_mom_t byte_moments(input logic [BITS_PER_BYTE-1:0] byte_in,
			input logic lsb_early);
		byte_mom_t res;
		int s0;
		int s1;
		int s2;
		int rem;
		logic [2:0] pos;
		s0 = 0;
		s1 = 0;
		s2 = 0;
		for (int t = 0; t < BITS_PER_BYTE; t++) begin
			pos = lsb_early ? 3'(t) : 3'(BITS_PER_BYTE - 1 - t);
			rem = BITS_PER_BYTE - t;
			if (byte_in[pos]) begin
				s0 = s0 + 1;
				s1 = s1 + rem;
				s2 = s2 + ((rem * (rem + 1)) >>> 1);
			end else begin
				s0 = s0 - 1;
				s1 = s1 - rem;
				s2 = s2 - ((rem * (rem + 1)) >>> 1);
			end
		end
		res.m0 = BM0_W'(s0);
		res.m1 = BM1_W'(s1);
		res.m2 = BM2_W'(s2);
		return res;
	endfunction

	// Number of samples of the item that come after byte b.
	function automatic int samples_after(input int b);
		return ITEM_LEN - BITS_PER_BYTE * (b + 1);
	endfunction

	function automatic int tri_num(input int n);
		return (n * (n + 1)) >>> 1;
	endfunction

endpackage

@@ rtl/dsdcic_moments.sv @@
// Moment stages of one channel: per-byte moments, then the item's three moments.
// Depends on dsdcic_pkg.
module dsdcic_moments
	import dsdcic_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic             lsb_early,
	input  logic [DSD_W-1:0] dsd,
	output item_mom_t        mom_s3
);

	byte_mom_t bm_s2 [BYTES];
	item_mom_t mom_d;

	// Byte 0 sits in the top byte and is the earliest in time.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < BYTES; b++) begin
				bm_s2[b] <= byte_moments(dsd[(BYTES-1-b)*BITS_PER_BYTE +: BITS_PER_BYTE],
					lsb_early);
			end
		end
	end

	// A byte followed by r samples adds r to every remaining-count weight of its samples.
	always_comb begin
		mom_d = '0;
		for (int b = 0; b < BYTES; b++) begin
			mom_d.m0 = mom_d.m0 + IM0_W'(bm_s2[b].m0);
			mom_d.m1 = mom_d.m1 + IM1_W'(bm_s2[b].m1)
				+ IM1_W'(bm_s2[b].m0) * IM1_W'(samples_after(b));
			mom_d.m2 = mom_d.m2 + IM2_W'(bm_s2[b].m2)
				+ IM2_W'(bm_s2[b].m1) * IM2_W'(samples_after(b))
				+ IM2_W'(bm_s2[b].m0) * IM2_W'(tri_num(samples_after(b)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mom_s3 <= mom_d;
		end
	end

endmodule

@@ rtl/dsdcic_chan.sv @@
// Integrator and comb section of one channel, with its output register.
// Depends on dsdcic_pkg.
module dsdcic_chan
	import dsdcic_pkg::*;
#(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stage_ctl_t              integ_ctl,
	input  stage_ctl_t              comb_ctl,
	input  item_mom_t               mom_s3,
	output logic signed [PCM_W-1:0] pcm_s5
);

	logic [ACC_WIDTH-1:0] ig0_q, ig1_q, ig2_q;
	logic [ACC_WIDTH-1:0] dl0_q, dl1_q, dl2_q;
	logic [ACC_WIDTH-1:0] base0, base1, base2;
	logic [ACC_WIDTH-1:0] ig0_d, ig1_d, ig2_d;
	logic [ACC_WIDTH-1:0] c0, c1, c2;
	logic [ACC_WIDTH-1:0] d1, d2, d3;

	// Closed form of 64 cascaded integrator steps.
	always_comb begin
		base0 = integ_ctl.restart ? '0 : ig0_q;
		base1 = integ_ctl.restart ? '0 : ig1_q;
		base2 = integ_ctl.restart ? '0 : ig2_q;
		ig0_d = base0 + ACC_WIDTH'(mom_s3.m0);
		ig1_d = base1 + base0 * ACC_WIDTH'(ITEM_LEN) + ACC_WIDTH'(mom_s3.m1);
		ig2_d = base2 + base1 * ACC_WIDTH'(ITEM_LEN) + base0 * ACC_WIDTH'(ITEM_TRI)
			+ ACC_WIDTH'(mom_s3.m2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ig0_q <= '0;
			ig1_q <= '0;
			ig2_q <= '0;
		end else if (integ_ctl.load) begin
			ig0_q <= ig0_d;
			ig1_q <= ig1_d;
			ig2_q <= ig2_d;
		end
	end

	always_comb begin
		c0 = comb_ctl.restart ? '0 : dl0_q;
		c1 = comb_ctl.restart ? '0 : dl1_q;
		c2 = comb_ctl.restart ? '0 : dl2_q;
		d1 = ig2_q - c0;
		d2 = d1 - c1;
		d3 = d2 - c2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl0_q <= '0;
			dl1_q <= '0;
			dl2_q <= '0;
		end else if (comb_ctl.load) begin
			dl0_q <= ig2_q;
			dl1_q <= d1;
			dl2_q <= d2;
		end
	end

	always_ff @(posedge clk) begin
		if (comb_ctl.load) begin
			pcm_s5 <= {d3[PCM_W-PCM_SHIFT-1:0], {PCM_SHIFT{1'b0}}};
		end
	end

	// After a restart the first two integrators hold only this item's moments.
	a_restart_ig0: assert property (@(posedge clk) disable iff (!arst_n)
		integ_ctl.load && integ_ctl.restart
		|=> (ig0_q + ACC_WIDTH'(ITEM_LEN)) <= ACC_WIDTH'(2 * ITEM_LEN))
		else $error("first integrator out of range after restart");

	a_restart_ig1: assert property (@(posedge clk) disable iff (!arst_n)
		integ_ctl.load && integ_ctl.restart
		|=> (ig1_q + ACC_WIDTH'(ITEM_TRI)) <= ACC_WIDTH'(2 * ITEM_TRI))
		else $error("second integrator out of range after restart");

endmodule

@@ rtl/dsd_cic_decimator_stereo.sv @@
// Stereo third-order CIC decimator, 1-bit DSD to PCM by 64, top level.
// Throughput: one beat per cycle; the five-register pipeline moves whenever the output is free.
// Reset (arst_n, asynchronous, active low) clears all integrators, comb delays, the
// pipeline valid flags and bit_order; the block is ready as soon as reset is released.
// Depends on dsdcic_pkg, dsdcic_moments and dsdcic_chan.
module dsd_cic_decimator_stereo
	import dsdcic_pkg::*;
#(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: bit_order, 0 = MSB of each byte earliest, 1 = LSB earliest.
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // left_dsd [63:0], right_dsd [127:64]
	input  logic                   s_tuser,   // restart
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata    // left_pcm [29:0], right_pcm [59:30], zero
);

	logic             bit_order_q;
	logic             en;
	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic             restart_s1, restart_s2, restart_s3, restart_s4;
	logic [DSD_W-1:0] left_s1, right_s1;
	item_mom_t        left_mom_s3, right_mom_s3;
	stage_ctl_t       integ_ctl, comb_ctl;
	logic signed [PCM_W-1:0] left_pcm_s5, right_pcm_s5;

	// The pipeline moves as one: every stage shifts when the output register is empty or
	// its beat is being taken. Empty stages simply travel as bubbles with their valid low.
	assign en       = !valid_s5 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_order_q <= 1'b0;
		end else if (cfg_we) begin
			bit_order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			valid_s5   <= 1'b0;
			restart_s1 <= 1'b0;
			restart_s2 <= 1'b0;
			restart_s3 <= 1'b0;
			restart_s4 <= 1'b0;
		end else if (en) begin
			valid_s1   <= s_tvalid;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			valid_s4   <= valid_s3;
			valid_s5   <= valid_s4;
			restart_s1 <= s_tuser;
			restart_s2 <= restart_s1;
			restart_s3 <= restart_s2;
			restart_s4 <= restart_s3;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			left_s1  <= s_tdata[DSD_W-1:0];
			right_s1 <= s_tdata[TDATA_IN_W-1:DSD_W];
		end
	end

	// Stages two and three: byte, then item moments. They hold no state, so the bit order is
	// read directly; the user must change it only while the pipeline is empty (not enforced).
	dsdcic_moments u_left_mom (
		.clk       (clk),
		.en        (en),
		.lsb_early (bit_order_q),
		.dsd       (left_s1),
		.mom_s3    (left_mom_s3)
	);

	dsdcic_moments u_right_mom (
		.clk       (clk),
		.en        (en),
		.lsb_early (bit_order_q),
		.dsd       (right_s1),
		.mom_s3    (right_mom_s3)
	);

	// Stage four updates the integrators, stage five runs the combs into the output
	// register. A restart beat clears each stage's state just as it reaches that stage,
	// so beats still behind it are never affected early.
	always_comb begin
		integ_ctl.load    = en && valid_s3;
		integ_ctl.restart = restart_s3;
		comb_ctl.load     = en && valid_s4;
		comb_ctl.restart  = restart_s4;
	end

	dsdcic_chan #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_left_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.integ_ctl (integ_ctl),
		.comb_ctl  (comb_ctl),
		.mom_s3    (left_mom_s3),
		.pcm_s5    (left_pcm_s5)
	);

	dsdcic_chan #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_right_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.integ_ctl (integ_ctl),
		.comb_ctl  (comb_ctl),
		.mom_s3    (right_mom_s3),
		.pcm_s5    (right_pcm_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {{(TDATA_OUT_W - 2 * PCM_W){1'b0}}, right_pcm_s5, left_pcm_s5};

	// A new beat can only enter while the output register is free or being emptied.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tready)
		else $error("input beat accepted while the output is stalled");

	// The scaling by 1024 leaves the low bits of both samples clear.
	a_scaled_lsbs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PCM_SHIFT-1:0] == '0)
			&& (m_tdata[PCM_W+PCM_SHIFT-1:PCM_W] == '0))
		else $error("PCM sample not a multiple of 1024");

endmodule
